/* rtl/lpfd_pkg.sv */
// Shared types, constants and the CRC-16/XMODEM byte update for the frame decoder.
package lpfd_pkg;

    localparam int unsigned MaxPayloadDefault = 256;
    localparam logic [7:0]  StartMarkerReset  = 8'hAA;
    localparam logic [15:0] CrcPoly           = 16'h1021;
    localparam logic [15:0] CrcInit           = 16'h0000;
    localparam logic [9:0]  PosCap            = 10'd1023;
    localparam logic [9:0]  MinFrame          = 10'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_BAD_START = 3'd2,
        VERDICT_LEN_BAD   = 3'd3,
        VERDICT_TOO_LONG  = 3'd4,
        VERDICT_CRC_BAD   = 3'd5
    } verdict_t;

    typedef struct packed {
        logic       emit;
        logic       kind;
        logic [7:0] data;
        verdict_t   verdict;
        logic [8:0] count;
    } lpfd_result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/length_prefixed_frame_decoder.sv */
// Top level of the length-prefixed frame decoder with CRC-16/XMODEM check.
// The decoder takes one frame byte per cycle with no gaps of its own: each byte is
// captured in an input register, decoded combinationally against the frame
// state (the byte-wide CRC update is a shallow tree of XOR logic), and its
// result, if any, lands in an output register. A stalled result holds the
// input register, which then stalls the input. Payload bytes come out
// tentatively; the last byte of a frame yields a verdict carrying the type
// byte and, on success, the payload length.
// The start marker can be rewritten at any time the decoder is idle.
module length_prefixed_frame_decoder #(
    parameter int unsigned MAX_PAYLOAD = lpfd_pkg::MaxPayloadDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       end_of_frame,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       result_kind,
    output logic [7:0] result_byte,
    output logic [2:0] verdict,
    output logic [8:0] payload_count,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import lpfd_pkg::*;

    logic         s1_valid_reg, s1_valid_next;
    logic [7:0]   s1_byte_reg;
    logic         s1_eof_reg;
    logic         out_valid_reg, out_valid_next;
    logic         out_kind_reg;
    logic [7:0]   out_byte_reg;
    logic [2:0]   out_verdict_reg;
    logic [8:0]   out_count_reg;
    logic         out_free;
    logic         advance;
    logic         load_in;
    lpfd_result_t result;

    assign out_free       = !out_valid_reg || !out_stall;
    assign advance        = s1_valid_reg && out_free;
    assign in_stall       = s1_valid_reg && !out_free;
    assign load_in        = in_valid && !in_stall;
    assign s1_valid_next  = load_in || (s1_valid_reg && !advance);
    assign out_valid_next = advance ? result.emit : (out_valid_reg && out_stall);
    assign cfg_ready      = 1'b1;

    lpfd_frame #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .rx_byte      (s1_byte_reg),
        .end_of_frame (s1_eof_reg),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            s1_byte_reg <= rx_byte;
            s1_eof_reg  <= end_of_frame;
        end
        if (advance && result.emit)
        begin
            out_kind_reg    <= result.kind;
            out_byte_reg    <= result.data;
            out_verdict_reg <= result.verdict;
            out_count_reg   <= result.count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_kind_reg;
    assign result_byte   = out_byte_reg;
    assign verdict       = out_verdict_reg;
    assign payload_count = out_count_reg;

endmodule

/* rtl/lpfd_frame.sv */
// Frame state registers and the per-byte decode step that forms payload and verdict results.
module lpfd_frame #(
    parameter int unsigned MAX_PAYLOAD = lpfd_pkg::MaxPayloadDefault
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    input  logic                   end_of_frame,
    input  logic                   cfg_write,
    input  logic [7:0]             cfg_data,
    output lpfd_pkg::lpfd_result_t result
);
    import lpfd_pkg::*;

    localparam logic [16:0] TooLongLimit = 17'(MAX_PAYLOAD) + 17'd1;

    logic [7:0]  marker_reg;
    logic [9:0]  pos_reg,  pos_next;
    logic [15:0] len_reg,  len_next,  len_new;
    logic [7:0]  type_reg, type_next, type_new;
    logic [15:0] crc_reg,  crc_next,  crc_new, crc_upd;
    logic [7:0]  crc_lo_reg, crc_lo_next, crc_lo_new;
    logic        start_ok_reg, start_ok_next, start_ok_new;
    logic        in_body;
    logic        is_crc_lo;
    logic        past_len;
    logic [9:0]  count;
    logic [16:0] expected;
    verdict_t    verdict;

    always_comb
    begin
        crc_upd   = crc_byte(crc_reg, rx_byte);
        past_len  = (pos_reg >= 10'd3);
        in_body   = ({7'd0, pos_reg} <= ({1'b0, len_reg} + 17'd2));
        is_crc_lo = ({7'd0, pos_reg} == ({1'b0, len_reg} + 17'd3));

        len_new = len_reg;
        if (pos_reg == 10'd1)
        begin
            len_new[7:0] = rx_byte;
        end
        if (pos_reg == 10'd2)
        begin
            len_new[15:8] = rx_byte;
        end

        crc_new = crc_reg;
        if (pos_reg == 10'd1 || pos_reg == 10'd2)
        begin
            crc_new = crc_upd;
        end
        else if (past_len && in_body && !end_of_frame)
        begin
            crc_new = crc_upd;
        end

        type_new     = (pos_reg == 10'd3) ? rx_byte : type_reg;
        crc_lo_new   = (past_len && !in_body && is_crc_lo) ? rx_byte : crc_lo_reg;
        start_ok_new = (pos_reg == 10'd0) ? (rx_byte == marker_reg) : start_ok_reg;

        count    = (pos_reg == PosCap) ? PosCap : pos_reg + 10'd1;
        expected = {1'b0, len_new} + 17'd5;

        if (count < MinFrame)
        begin
            verdict = VERDICT_SHORT;
        end
        else if (!start_ok_new)
        begin
            verdict = VERDICT_BAD_START;
        end
        else if ({7'd0, count} != expected)
        begin
            verdict = VERDICT_LEN_BAD;
        end
        else if ({1'b0, len_new} > TooLongLimit)
        begin
            verdict = VERDICT_TOO_LONG;
        end
        else if (crc_new != {rx_byte, crc_lo_new})
        begin
            verdict = VERDICT_CRC_BAD;
        end
        else
        begin
            verdict = VERDICT_OK;
        end

        if (end_of_frame)
        begin
            result.emit    = 1'b1;
            result.kind    = KIND_VERDICT;
            result.data    = type_new;
            result.verdict = verdict;
            result.count   = (verdict == VERDICT_OK) ? 9'(len_new - 16'd1) : 9'd0;
        end
        else
        begin
            result.emit    = (pos_reg >= 10'd4) && in_body;
            result.kind    = KIND_PAYLOAD;
            result.data    = rx_byte;
            result.verdict = VERDICT_OK;
            result.count   = 9'd0;
        end

        if (end_of_frame)
        begin
            pos_next      = 10'd0;
            len_next      = 16'd0;
            type_next     = 8'd0;
            crc_next      = CrcInit;
            crc_lo_next   = 8'd0;
            start_ok_next = 1'b0;
        end
        else
        begin
            pos_next      = count;
            len_next      = len_new;
            type_next     = type_new;
            crc_next      = crc_new;
            crc_lo_next   = crc_lo_new;
            start_ok_next = start_ok_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg   <= StartMarkerReset;
            pos_reg      <= 10'd0;
            len_reg      <= 16'd0;
            type_reg     <= 8'd0;
            crc_reg      <= CrcInit;
            crc_lo_reg   <= 8'd0;
            start_ok_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                marker_reg <= cfg_data;
            end
            if (step)
            begin
                pos_reg      <= pos_next;
                len_reg      <= len_next;
                type_reg     <= type_next;
                crc_reg      <= crc_next;
                crc_lo_reg   <= crc_lo_next;
                start_ok_reg <= start_ok_next;
            end
        end
    end

endmodule

/* rtl/lpfd_checker.sv */
// Port-level checks for the frame decoder and the bind that attaches them.
module lpfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       result_kind,
    input logic [7:0] result_byte,
    input logic [2:0] verdict,
    input logic [8:0] payload_count
);
    import lpfd_pkg::*;

    // A stalled result stays in place with its contents unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind)
            && $stable(result_byte) && $stable(verdict) && $stable(payload_count))
    else $error("stalled result changed");

    // Tentative payload transfers carry no verdict and no count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_PAYLOAD) |->
            (verdict == VERDICT_OK) && (payload_count == 9'd0))
    else $error("payload transfer with verdict fields set");

    // A failed frame never reports a payload length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_VERDICT) && (verdict != VERDICT_OK) |->
            (payload_count == 9'd0))
    else $error("failed verdict with nonzero payload count");

endmodule

bind length_prefixed_frame_decoder lpfd_checker u_lpfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .result_byte   (result_byte),
    .verdict       (verdict),
    .payload_count (payload_count)
);
